// ----- hdl/rrq_pkg.sv -----
// ============================================================================
// rrq_pkg
// Shared types, request and result codes and RED constants for the router
// admission and output queue.
// ============================================================================
package rrq_pkg;

    // Fixed field widths of the stream words.
    localparam int PORT_W   = 3;
    localparam int PID_W    = 32;
    localparam int DRAW_W   = 16;
    localparam int BOFF_W   = 2;
    localparam int KIND_W   = 3;
    localparam int REQ_W    = 3;
    localparam int QLEN_W   = 4;
    localparam int CNT32_W  = 32;
    localparam int CAP_W    = 4;
    localparam int MASK_W   = 8;

    // Stream word widths, padded to whole bytes.
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 112;

    // Port count follows from the 3-bit port fields.
    localparam int NUM_PORTS = 1 << PORT_W;

    // Drop statistics buckets, indexed by queue length capped at BUCKET_CAP.
    localparam int NUM_BUCKETS = 7;
    localparam int BKT_W       = 3;
    localparam int BUCKET_CAP  = 6;

    // Default queue depth.
    localparam int BUFFER_DEPTH_DEF = 8;

    // RED drop thresholds on the 16-bit draw: 0.2 * 65536 rounded up.
    localparam logic [DRAW_W-1:0] RED_THR_LEN2 = 16'd13108;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ARRIVAL = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PASS    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TICK    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd4;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_STORED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CAP_DROP = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RED_DROP = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FORWARD  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_COUNTERS = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NOTHING  = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_CAPACITY  = 1'b0;
    localparam logic CFG_PEER_MASK = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CAP_W-1:0]  CAP_RESET  = 4'd1;
    localparam logic [MASK_W-1:0] MASK_RESET = 8'hFF;

    // One queued packet.
    typedef struct packed {
        logic [PID_W-1:0]  id;
        logic [PORT_W-1:0] dst;
        logic [PORT_W-1:0] src;
    } queue_entry_t;

    // Saturating 32-bit increment, shared by both drop counter banks.
    function automatic logic [CNT32_W-1:0] sat_inc(input logic [CNT32_W-1:0] val);
        logic [CNT32_W-1:0] res;
        if (&val) begin
            res = val;
        end else begin
            res = val + 32'd1;
        end
        return res;
    endfunction

endpackage

// ----- hdl/rrq_ram.sv -----
// ============================================================================
// rrq_ram
// Generic single-clock RAM with one write port and one registered read port.
// ============================================================================
module rrq_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/red_router_queue.sv -----
// Timing: the single result word of an arrival, tick, counter read, counter
//   clear or unknown request is registered from the EXEC state once the
//   output register is free. An output pass walks the queue RAM one entry per
//   cycle, except while a held forward waits on a stalled result side. A new
//   request is taken only in the idle state, after the last one is done.
// Reset: synchronous aresetn clears count, tick, drop counters and valid flags.
// ============================================================================
// red_router_queue
// Router admission stage with a per-tick limit and RED drops, followed by an
// output queue that forwards the oldest packet for each attached destination.
// ============================================================================
module red_router_queue
    import rrq_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Configuration write port.
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [MASK_W-1:0]    cfg_wdata,

    // Request stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // src_id[2:0], dst_id[5:3], packet_id[37:6], drop_random[53:38],
    // backoff_choice[55:54], stat_bucket[58:56], zero pad above
    input  logic [S_DATA_W-1:0]  s_tdata,
    // req_type[2:0]
    input  logic [REQ_W-1:0]     s_tuser,

    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // port_id[2:0], out_packet_id[34:3], origin_id[37:35], backoff[39:38],
    // queue_len[43:40], red_drops[75:44], capacity_drops[107:76], zero pad above
    output logic [M_DATA_W-1:0]  m_tdata,
    // kind[2:0]
    output logic [KIND_W-1:0]    m_tuser,
    output logic                 m_tlast
);

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int ENT_W = $bits(queue_entry_t);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_EXEC       = 3'd1;
    localparam logic [2:0] ST_PASS_START = 3'd2;
    localparam logic [2:0] ST_WALK       = 3'd3;
    localparam logic [2:0] ST_FINISH     = 3'd4;

    logic [2:0] state_reg, state_next;

    // Configuration registers.
    logic [CAP_W-1:0]  cap_tick_reg, cap_tick_next;
    logic [MASK_W-1:0] peer_mask_reg, peer_mask_next;

    // Latched request word.
    logic [REQ_W-1:0]  req_reg;
    logic [PORT_W-1:0] src_reg;
    logic [PORT_W-1:0] dst_reg;
    logic [PID_W-1:0]  pid_reg;
    logic [DRAW_W-1:0] draw_reg;
    logic [BOFF_W-1:0] boff_reg;
    logic [BKT_W-1:0]  sb_reg;

    // Queue and admission state.
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CAP_W-1:0]  acc_tick_reg, acc_tick_next;
    logic [CNT32_W-1:0] red_cnt_reg [NUM_BUCKETS];
    logic [CNT32_W-1:0] red_cnt_next [NUM_BUCKETS];
    logic [CNT32_W-1:0] cap_cnt_reg [NUM_BUCKETS];
    logic [CNT32_W-1:0] cap_cnt_next [NUM_BUCKETS];

    // Output pass walk state.
    logic [IDX_W-1:0]     walk_idx_reg, walk_idx_next;
    logic [CNT_W-1:0]     keep_cnt_reg, keep_cnt_next;
    logic [NUM_PORTS-1:0] sent_reg, sent_next;
    logic                 pend_valid_reg, pend_valid_next;
    queue_entry_t         pend_entry_reg, pend_entry_next;
    logic [CNT_W-1:0]     pend_qlen_reg, pend_qlen_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]   m_kind_reg, m_kind_next;
    logic [PORT_W-1:0]   m_port_reg, m_port_next;
    logic [PID_W-1:0]    m_pid_reg, m_pid_next;
    logic [PORT_W-1:0]   m_origin_reg, m_origin_next;
    logic [BOFF_W-1:0]   m_boff_reg, m_boff_next;
    logic [QLEN_W-1:0]   m_qlen_reg, m_qlen_next;
    logic [CNT32_W-1:0]  m_red_reg, m_red_next;
    logic [CNT32_W-1:0]  m_cap_reg, m_cap_next;
    logic                m_last_reg, m_last_next;

    // Queue RAM ports.
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    queue_entry_t     ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;
    queue_entry_t     rd_entry;

    // Datapath helpers.
    logic               out_free;
    logic               s_accept;
    logic [BKT_W-1:0]   arr_bucket;
    logic [BKT_W-1:0]   rd_bucket;
    logic               cap_hit;
    logic               red_hit;
    logic [BOFF_W-1:0]  boff_eff;
    logic [CNT32_W-1:0] inc_in;
    logic [CNT32_W-1:0] inc_out;
    logic               is_send;
    logic               walk_stall;
    logic               walk_last;

    rrq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = queue_entry_t'(ram_rdata);
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Bucket selection for arrivals and counter reads, both capped.
    assign arr_bucket = (int'(count_reg) > BUCKET_CAP) ? BKT_W'(BUCKET_CAP)
                                                       : BKT_W'(count_reg);
    assign rd_bucket  = (int'(sb_reg) > BUCKET_CAP) ? BKT_W'(BUCKET_CAP) : sb_reg;

    // Admission checks: tick limit first, then the RED curve and a full queue.
    assign cap_hit = (acc_tick_reg >= cap_tick_reg);
    always_comb begin
        if (count_reg >= CNT_W'(4)) begin
            red_hit = 1'b1;
        end else if (count_reg == CNT_W'(3)) begin
            red_hit = !draw_reg[DRAW_W-1];
        end else if (count_reg == CNT_W'(2)) begin
            red_hit = (draw_reg < RED_THR_LEN2);
        end else begin
            red_hit = 1'b0;
        end
        if (count_reg >= CNT_W'(BUFFER_DEPTH)) begin
            red_hit = 1'b1;
        end
    end

    assign boff_eff = (boff_reg == '0) ? BOFF_W'(1) : boff_reg;

    // Shared saturating incrementer for whichever bank takes the drop.
    assign inc_in  = cap_hit ? cap_cnt_reg[arr_bucket] : red_cnt_reg[arr_bucket];
    assign inc_out = sat_inc(inc_in);

    // Walk decisions on the entry currently on the RAM read port.
    assign is_send    = !sent_reg[rd_entry.dst] && peer_mask_reg[rd_entry.dst];
    assign walk_stall = is_send && pend_valid_reg && !out_free;
    assign walk_last  = ((CNT_W'(walk_idx_reg) + CNT_W'(1)) == count_reg);

    // Sequencer and next-state logic.
    always_comb begin
        state_next      = state_reg;
        cap_tick_next   = cap_tick_reg;
        peer_mask_next  = peer_mask_reg;
        count_next      = count_reg;
        acc_tick_next   = acc_tick_reg;
        red_cnt_next    = red_cnt_reg;
        cap_cnt_next    = cap_cnt_reg;
        walk_idx_next   = walk_idx_reg;
        keep_cnt_next   = keep_cnt_reg;
        sent_next       = sent_reg;
        pend_valid_next = pend_valid_reg;
        pend_entry_next = pend_entry_reg;
        pend_qlen_next  = pend_qlen_reg;

        m_valid_next  = m_valid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_port_next   = m_port_reg;
        m_pid_next    = m_pid_reg;
        m_origin_next = m_origin_reg;
        m_boff_next   = m_boff_reg;
        m_qlen_next   = m_qlen_reg;
        m_red_next    = m_red_reg;
        m_cap_next    = m_cap_reg;
        m_last_next   = m_last_reg;

        ram_we    = 1'b0;
        ram_waddr = IDX_W'(count_reg);
        ram_wdata = '{id: pid_reg, dst: dst_reg, src: src_reg};
        ram_raddr = walk_idx_reg;

        // Configuration writes are taken in any state.
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_CAPACITY:  cap_tick_next  = CAP_W'(cfg_wdata);
                CFG_PEER_MASK: peer_mask_next = cfg_wdata;
                default:       ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end

            // Single-result requests, and the entry to an output pass.
            ST_EXEC: begin
                if (req_reg == REQ_PASS) begin
                    state_next = ST_PASS_START;
                end else if (out_free) begin
                    state_next    = ST_IDLE;
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_NOTHING;
                    m_port_next   = '0;
                    m_pid_next    = '0;
                    m_origin_next = '0;
                    m_boff_next   = '0;
                    m_qlen_next   = QLEN_W'(count_reg);
                    m_red_next    = '0;
                    m_cap_next    = '0;
                    m_last_next   = 1'b1;
                    case (req_reg)
                        REQ_ARRIVAL: begin
                            m_pid_next    = pid_reg;
                            m_origin_next = src_reg;
                            if (cap_hit) begin
                                cap_cnt_next[arr_bucket] = inc_out;
                                m_kind_next = KIND_CAP_DROP;
                                m_port_next = src_reg;
                                m_boff_next = boff_eff;
                            end else if (red_hit) begin
                                red_cnt_next[arr_bucket] = inc_out;
                                m_kind_next = KIND_RED_DROP;
                                m_port_next = src_reg;
                                m_boff_next = boff_eff;
                            end else begin
                                ram_we      = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                                m_kind_next = KIND_STORED;
                                m_port_next = dst_reg;
                                m_qlen_next = QLEN_W'(count_reg + CNT_W'(1));
                                if (acc_tick_reg != '1) begin
                                    acc_tick_next = acc_tick_reg + CAP_W'(1);
                                end
                            end
                        end
                        REQ_TICK: begin
                            acc_tick_next = '0;
                        end
                        REQ_READ: begin
                            m_kind_next = KIND_COUNTERS;
                            m_red_next  = red_cnt_reg[rd_bucket];
                            m_cap_next  = cap_cnt_reg[rd_bucket];
                        end
                        REQ_CLEAR: begin
                            for (int b = 0; b < NUM_BUCKETS; b++) begin
                                red_cnt_next[b] = '0;
                                cap_cnt_next[b] = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Start the walk at the oldest entry.
            ST_PASS_START: begin
                walk_idx_next   = '0;
                keep_cnt_next   = '0;
                sent_next       = '0;
                pend_valid_next = 1'b0;
                ram_raddr       = '0;
                if (count_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_WALK;
                end
            end

            // One entry per cycle unless walk_stall holds: forward it or compact it down to keep_cnt.
            ST_WALK: begin
                if (!walk_stall) begin
                    ram_raddr = walk_idx_reg + IDX_W'(1);
                    if (is_send) begin
                        sent_next[rd_entry.dst] = 1'b1;
                        pend_valid_next = 1'b1;
                        pend_entry_next = rd_entry;
                        if (pend_valid_reg) begin
                            pend_qlen_next = pend_qlen_reg - CNT_W'(1);
                            m_valid_next   = 1'b1;
                            m_kind_next    = KIND_FORWARD;
                            m_port_next    = pend_entry_reg.dst;
                            m_pid_next     = pend_entry_reg.id;
                            m_origin_next  = pend_entry_reg.src;
                            m_boff_next    = '0;
                            m_qlen_next    = QLEN_W'(pend_qlen_reg);
                            m_red_next     = '0;
                            m_cap_next     = '0;
                            m_last_next    = 1'b0;
                        end else begin
                            pend_qlen_next = count_reg - CNT_W'(1);
                        end
                    end else begin
                        ram_we        = 1'b1;
                        ram_waddr     = IDX_W'(keep_cnt_reg);
                        ram_wdata     = rd_entry;
                        keep_cnt_next = keep_cnt_reg + CNT_W'(1);
                    end
                    if (walk_last) begin
                        state_next = ST_FINISH;
                    end else begin
                        walk_idx_next = walk_idx_reg + IDX_W'(1);
                    end
                end
            end

            // Close the pass with the held forward, or a nothing word.
            ST_FINISH: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_valid_next  = 1'b1;
                    m_boff_next   = '0;
                    m_red_next    = '0;
                    m_cap_next    = '0;
                    m_last_next   = 1'b1;
                    if (pend_valid_reg) begin
                        pend_valid_next = 1'b0;
                        count_next      = keep_cnt_reg;
                        m_kind_next     = KIND_FORWARD;
                        m_port_next     = pend_entry_reg.dst;
                        m_pid_next      = pend_entry_reg.id;
                        m_origin_next   = pend_entry_reg.src;
                        m_qlen_next     = QLEN_W'(pend_qlen_reg);
                    end else begin
                        m_kind_next   = KIND_NOTHING;
                        m_port_next   = '0;
                        m_pid_next    = '0;
                        m_origin_next = '0;
                        m_qlen_next   = QLEN_W'(count_reg);
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cap_tick_reg   <= CAP_RESET;
            peer_mask_reg  <= MASK_RESET;
            count_reg      <= '0;
            acc_tick_reg   <= '0;
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                red_cnt_reg[b] <= '0;
                cap_cnt_reg[b] <= '0;
            end
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cap_tick_reg   <= cap_tick_next;
            peer_mask_reg  <= peer_mask_next;
            count_reg      <= count_next;
            acc_tick_reg   <= acc_tick_next;
            red_cnt_reg    <= red_cnt_next;
            cap_cnt_reg    <= cap_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg  <= s_tuser;
            src_reg  <= s_tdata[2:0];
            dst_reg  <= s_tdata[5:3];
            pid_reg  <= s_tdata[37:6];
            draw_reg <= s_tdata[53:38];
            boff_reg <= s_tdata[55:54];
            sb_reg   <= s_tdata[58:56];
        end
        walk_idx_reg   <= walk_idx_next;
        keep_cnt_reg   <= keep_cnt_next;
        sent_reg       <= sent_next;
        pend_entry_reg <= pend_entry_next;
        pend_qlen_reg  <= pend_qlen_next;
        m_kind_reg     <= m_kind_next;
        m_port_reg     <= m_port_next;
        m_pid_reg      <= m_pid_next;
        m_origin_reg   <= m_origin_next;
        m_boff_reg     <= m_boff_next;
        m_qlen_reg     <= m_qlen_next;
        m_red_reg      <= m_red_next;
        m_cap_reg      <= m_cap_next;
        m_last_reg     <= m_last_next;
    end

    // Result word packing.
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'd0, m_cap_reg, m_red_reg, m_qlen_reg, m_boff_reg,
                       m_origin_reg, m_pid_reg, m_port_reg};

`ifndef SYNTHESIS
    // The queue never holds more than its depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(BUFFER_DEPTH))
        else $error("queue count above depth");

    // Compaction never overtakes the entry being read.
    a_keep_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (keep_cnt_reg <= CNT_W'(walk_idx_reg)))
        else $error("kept entries overtake the walk");

    // No forward is left held once the pass has ended.
    a_no_pending_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held forward left after pass");

    // A pass only shrinks the queue.
    a_pass_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && pend_valid_reg && out_free)
            |=> (count_reg < $past(count_reg)))
        else $error("output pass did not shrink queue");
`endif

endmodule

// ----- bench/rrq_checker.sv -----
// ============================================================================
// rrq_checker
// Watches the request, result and configuration ports of red_router_queue.
// It keeps its own copy of the queue, the tick count, the drop counters and
// the registers, works out the result words that each accepted request must
// produce, and compares every accepted result word with the oldest one due.
// ============================================================================
module rrq_checker
    import rrq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [MASK_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic [REQ_W-1:0]     s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_DATA_W-1:0]  m_tdata,
    input  logic [KIND_W-1:0]    m_tuser,
    input  logic                 m_tlast,
    output int                   mismatches,
    output int                   results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // RED thresholds on the draw, one bit wider so that "always" fits.
    localparam logic [DRAW_W:0] RED_NEVER   = 17'h00000;
    localparam logic [DRAW_W:0] RED_HALF    = 17'h08000;
    localparam logic [DRAW_W:0] RED_CERTAIN = 17'h10000;
    localparam int              MAX_REPORTS = 10;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [PORT_W-1:0]  port;
        logic [PID_W-1:0]   pid;
        logic [PORT_W-1:0]  origin;
        logic [BOFF_W-1:0]  backoff;
        logic [QLEN_W-1:0]  qlen;
        logic [CNT32_W-1:0] red;
        logic [CNT32_W-1:0] cap;
        logic               last;
    } result_word_t;

    // Predicted block state.
    queue_entry_t       held [BUFFER_DEPTH_DEF];
    logic [QLEN_W-1:0]  held_count;
    logic [CAP_W-1:0]   stored_this_tick;
    logic [CAP_W-1:0]   tick_limit;
    logic [MASK_W-1:0]  attached;
    logic [CNT32_W-1:0] red_tally [NUM_BUCKETS];
    logic [CNT32_W-1:0] cap_tally [NUM_BUCKETS];

    // Result words still owed by the block, oldest first.
    result_word_t awaited_results[$];

    function automatic result_word_t word_of(
        input logic [KIND_W-1:0]  kind,
        input logic [PORT_W-1:0]  port,
        input logic [PID_W-1:0]   pid,
        input logic [PORT_W-1:0]  origin,
        input logic [BOFF_W-1:0]  backoff,
        input logic [QLEN_W-1:0]  qlen,
        input logic [CNT32_W-1:0] red,
        input logic [CNT32_W-1:0] cap,
        input logic               last
    );
        result_word_t w;
        w.kind    = kind;
        w.port    = port;
        w.pid     = pid;
        w.origin  = origin;
        w.backoff = backoff;
        w.qlen    = qlen;
        w.red     = red;
        w.cap     = cap;
        w.last    = last;
        return w;
    endfunction

    // Drop counters stick at all ones.
    function automatic logic [CNT32_W-1:0] bumped(input logic [CNT32_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic string describe(input result_word_t w);
        return $sformatf("kind %0d port %0d id %h origin %0d backoff %0d qlen %0d red %0d cap %0d last %0d",
                         w.kind, w.port, w.pid, w.origin, w.backoff, w.qlen,
                         w.red, w.cap, w.last);
    endfunction

    // Admission, RED and output pass: queue up the words one request causes.
    task automatic route_request(input logic [REQ_W-1:0] req,
                                 input logic [S_DATA_W-1:0] data);
        logic [PORT_W-1:0]    src;
        logic [PORT_W-1:0]    dst;
        logic [PID_W-1:0]     pid;
        logic [DRAW_W:0]      draw;
        logic [BOFF_W-1:0]    boff;
        logic [BKT_W-1:0]     bucket;
        logic [DRAW_W:0]      thresh;
        logic [NUM_PORTS-1:0] sent_to;
        queue_entry_t         kept [BUFFER_DEPTH_DEF];
        queue_entry_t         sent [BUFFER_DEPTH_DEF];
        int                   nk;
        int                   ns;
        int                   i;

        src    = data[2:0];
        dst    = data[5:3];
        pid    = data[37:6];
        draw   = {1'b0, data[53:38]};
        boff   = data[55:54];
        nk     = 0;
        ns     = 0;
        sent_to = '0;

        case (req)
            REQ_ARRIVAL: begin
                bucket = (held_count > BUCKET_CAP) ? BKT_W'(BUCKET_CAP) : BKT_W'(held_count);
                if (boff == '0) begin
                    boff = BOFF_W'(1);
                end
                if (held_count >= 4) begin
                    thresh = RED_CERTAIN;
                end else if (held_count == 3) begin
                    thresh = RED_HALF;
                end else if (held_count == 2) begin
                    thresh = {1'b0, RED_THR_LEN2};
                end else begin
                    thresh = RED_NEVER;
                end

                // The per-tick limit is checked before RED.
                if (stored_this_tick >= tick_limit) begin
                    cap_tally[bucket] = bumped(cap_tally[bucket]);
                    awaited_results.push_back(word_of(KIND_CAP_DROP, src, pid, src, boff,
                                                      held_count, '0, '0, 1'b1));
                end else if (draw < thresh || held_count >= BUFFER_DEPTH_DEF) begin
                    red_tally[bucket] = bumped(red_tally[bucket]);
                    awaited_results.push_back(word_of(KIND_RED_DROP, src, pid, src, boff,
                                                      held_count, '0, '0, 1'b1));
                end else begin
                    held[held_count].id  = pid;
                    held[held_count].dst = dst;
                    held[held_count].src = src;
                    held_count = held_count + 1'b1;
                    if (stored_this_tick != '1) begin
                        stored_this_tick = stored_this_tick + 1'b1;
                    end
                    awaited_results.push_back(word_of(KIND_STORED, dst, pid, src, '0,
                                                      held_count, '0, '0, 1'b1));
                end
            end
            REQ_PASS: begin
                // The oldest packet of each attached destination leaves.
                for (i = 0; i < held_count; i++) begin
                    if (!sent_to[held[i].dst] && attached[held[i].dst]) begin
                        sent_to[held[i].dst] = 1'b1;
                        sent[ns] = held[i];
                        ns++;
                    end else begin
                        kept[nk] = held[i];
                        nk++;
                    end
                end
                if (ns == 0) begin
                    awaited_results.push_back(word_of(KIND_NOTHING, '0, '0, '0, '0,
                                                      held_count, '0, '0, 1'b1));
                end else begin
                    for (i = 0; i < ns; i++) begin
                        awaited_results.push_back(word_of(KIND_FORWARD, sent[i].dst,
                            sent[i].id, sent[i].src, '0, QLEN_W'(int'(held_count) - i - 1),
                            '0, '0, (i + 1 == ns)));
                    end
                    for (i = 0; i < nk; i++) begin
                        held[i] = kept[i];
                    end
                    held_count = QLEN_W'(nk);
                end
            end
            REQ_READ: begin
                bucket = (data[58:56] > BUCKET_CAP) ? BKT_W'(BUCKET_CAP) : data[58:56];
                awaited_results.push_back(word_of(KIND_COUNTERS, '0, '0, '0, '0, held_count,
                                                  red_tally[bucket], cap_tally[bucket], 1'b1));
            end
            default: begin
                // New tick, clear and the spare codes answer with an empty word.
                if (req == REQ_TICK) begin
                    stored_this_tick = '0;
                end else if (req == REQ_CLEAR) begin
                    for (i = 0; i < NUM_BUCKETS; i++) begin
                        red_tally[i] = '0;
                        cap_tally[i] = '0;
                    end
                end
                awaited_results.push_back(word_of(KIND_NOTHING, '0, '0, '0, '0,
                                                  held_count, '0, '0, 1'b1));
            end
        endcase
    endtask

    always @(posedge aclk) begin
        result_word_t got;
        result_word_t want;

        if (!aresetn) begin
            held_count       = '0;
            stored_this_tick = '0;
            tick_limit       = CAP_RESET;
            attached         = MASK_RESET;
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                red_tally[b] = '0;
                cap_tally[b] = '0;
            end
            awaited_results.delete();
        end else begin
            // Register writes.
            if (cfg_we) begin
                if (cfg_addr == CFG_CAPACITY) begin
                    tick_limit = cfg_wdata[CAP_W-1:0];
                end else begin
                    attached = cfg_wdata;
                end
            end

            // Accepted request word.
            if (s_tvalid && s_tready) begin
                route_request(s_tuser, s_tdata);
            end

            // Accepted result word against the oldest one due.
            if (m_tvalid && m_tready) begin
                got.kind    = m_tuser;
                got.port    = m_tdata[2:0];
                got.pid     = m_tdata[34:3];
                got.origin  = m_tdata[37:35];
                got.backoff = m_tdata[39:38];
                got.qlen    = m_tdata[43:40];
                got.red     = m_tdata[75:44];
                got.cap     = m_tdata[107:76];
                got.last    = m_tlast;
                if (awaited_results.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("%t: result word with none due: %s", $realtime, describe(got));
                    end
                    mismatches <= mismatches + 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("%t: result word mismatch", $realtime);
                            $display("    expected %s", describe(want));
                            $display("    actual   %s", describe(got));
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
        results_due <= awaited_results.size();
    end

endmodule

// ----- bench/testbench.sv -----
// ============================================================================
// testbench
// Stimulus for red_router_queue: a directed run through the admission,
// RED, output pass and counter requests, then random traffic in three
// phases with different register settings and handshake idling. The
// checker beside the block predicts and compares every result word.
// ============================================================================
module testbench
    import rrq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 20;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 62;

    // Request codes the block treats as unknown.
    localparam logic [REQ_W-1:0] REQ_SPARE_5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_we;
    logic                cfg_addr;
    logic [MASK_W-1:0]   cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [REQ_W-1:0]    s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]   m_tuser;
    logic                m_tlast;

    int mismatch_count;
    int results_due;
    int send_idle_pct;
    int ready_idle_pct;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    red_router_queue i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    rrq_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatch_count),
        .results_due (results_due)
    );

    // Result side stalls at random.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= ready_idle_pct);
    end

    // One of the request codes the block does not know.
    function automatic logic [REQ_W-1:0] REQ_Type_spare();
        case ($urandom_range(0, 2))
            0:       return REQ_SPARE_5;
            1:       return REQ_SPARE_6;
            default: return REQ_SPARE_7;
        endcase
    endfunction

    // Present one request word and hold it until it is taken.
    task automatic send_request(input logic [REQ_W-1:0]  req,
                                input logic [PORT_W-1:0] src,
                                input logic [PORT_W-1:0] dst,
                                input logic [PID_W-1:0]  pid,
                                input logic [DRAW_W-1:0] draw,
                                input logic [BOFF_W-1:0] boff,
                                input logic [BKT_W-1:0]  bucket);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= S_DATA_W'({bucket, boff, draw, pid, dst, src});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic arrive(input logic [PORT_W-1:0] src, input logic [PORT_W-1:0] dst,
                          input logic [PID_W-1:0] pid, input logic [DRAW_W-1:0] draw,
                          input logic [BOFF_W-1:0] boff);
        send_request(REQ_ARRIVAL, src, dst, pid, draw, boff, BKT_W'($urandom_range(0, 7)));
    endtask

    // Non-arrival request; the packet fields carry noise.
    task automatic ask(input logic [REQ_W-1:0] req, input logic [BKT_W-1:0] bucket);
        send_request(req, PORT_W'($urandom_range(0, 7)), PORT_W'($urandom_range(0, 7)),
                     $urandom(), DRAW_W'($urandom_range(0, 65535)),
                     BOFF_W'($urandom_range(0, 3)), bucket);
    endtask

    // Stop sending until every result word has come and the block is quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [CAP_W-1:0] cap, input logic [MASK_W-1:0] mask);
        settle();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_CAPACITY;
        cfg_wdata <= MASK_W'(cap);
        @(posedge aclk);
        cfg_addr  <= CFG_PEER_MASK;
        cfg_wdata <= mask;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int                pick;
        logic [DRAW_W-1:0] draw;

        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = CFG_CAPACITY;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = REQ_ARRIVAL;
        send_idle_pct  = 29;
        ready_idle_pct = 45;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty queue, RED at each length and both draw extremes,
        // destination 7 detached so it stays behind in the pass.
        set_regs(CAP_W'(8), 8'h7F);
        ask(REQ_PASS, '0);
        ask(REQ_READ, BKT_W'(7));
        arrive(3'd0, 3'd7, 32'h0000_0000, 16'h0000, 2'd0);
        arrive(3'd7, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 2'd3);
        arrive(3'd3, 3'd2, $urandom(), 16'h0000, 2'd0);
        arrive(3'd1, 3'd2, $urandom(), RED_THR_LEN2, 2'd1);
        arrive(3'd2, 3'd5, $urandom(), 16'h7FFF, 2'd2);
        arrive(3'd4, 3'd2, $urandom(), 16'h8000, 2'd3);
        arrive(3'd5, 3'd3, $urandom(), 16'hFFFF, 2'd0);
        ask(REQ_PASS, '0);
        ask(REQ_READ, BKT_W'(2));
        ask(REQ_READ, BKT_W'(3));
        ask(REQ_TICK, '0);
        ask(REQ_SPARE_5, '0);
        ask(REQ_SPARE_6, '0);
        ask(REQ_SPARE_7, '0);
        ask(REQ_CLEAR, '0);
        ask(REQ_READ, BKT_W'(4));

        // A limit of zero drops every arrival; all destinations attached.
        set_regs(CAP_W'(0), 8'hFF);
        arrive(3'd6, 3'd1, $urandom(), 16'hFFFF, 2'd2);
        ask(REQ_READ, BKT_W'(3));
        ask(REQ_PASS, '0);

        // Largest limit, nothing attached: the pass must send nothing.
        set_regs(CAP_W'(15), 8'h00);
        ask(REQ_PASS, '0);
        arrive(3'd2, 3'd6, $urandom(), 16'hFFFF, 2'd1);

        // Random traffic in three idling phases.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 29 : (phase == 1) ? 45 : 0;
            ready_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 29 : 0;
            if (phase == 0) begin
                set_regs(CAP_W'(4), 8'hFF);
            end else if (phase == 1) begin
                set_regs(CAP_W'($urandom_range(1, 8)), MASK_W'($urandom_range(0, 255)));
            end else begin
                set_regs(CAP_W'(8), 8'h5A);
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 1 && n == PHASE_ITEMS / 2) begin
                    settle();
                end
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    // Draws cluster on the RED thresholds now and then.
                    case ($urandom_range(0, 11))
                        0:       draw = '0;
                        1:       draw = '1;
                        2:       draw = RED_THR_LEN2 - 1'b1;
                        3:       draw = RED_THR_LEN2;
                        4:       draw = 16'h7FFF;
                        5:       draw = 16'h8000;
                        default: draw = DRAW_W'($urandom_range(0, 65535));
                    endcase
                    arrive(PORT_W'($urandom_range(0, 7)), PORT_W'($urandom_range(0, 7)),
                           $urandom(), draw, BOFF_W'($urandom_range(0, 3)));
                end else if (pick < 70) begin
                    ask(REQ_PASS, BKT_W'($urandom_range(0, 7)));
                end else if (pick < 85) begin
                    ask(REQ_TICK, BKT_W'($urandom_range(0, 7)));
                end else if (pick < 94) begin
                    ask(REQ_READ, BKT_W'($urandom_range(0, 7)));
                end else if (pick < 97) begin
                    ask(REQ_CLEAR, BKT_W'($urandom_range(0, 7)));
                end else begin
                    ask(REQ_Type_spare(), BKT_W'($urandom_range(0, 7)));
                end
            end
        end

        settle();
        if (mismatch_count == 0 && results_due == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule
